[rtl/rpba_pkg.sv]
// types, codes and constants shared by the page bump allocator
`default_nettype none
package rpba_pkg;

  localparam int PAGE_COUNT = 64;
  localparam int PAGE_BITS  = 6;
  localparam int WORD_BITS  = 13;
  localparam int COUNT_BITS = 7;
  localparam int GROUP_SIZE = 8;
  localparam int GROUP_BITS = 3;
  localparam int GROUPS     = PAGE_COUNT / GROUP_SIZE;

  localparam logic [WORD_BITS-1:0]  USABLE_WORDS = 13'd8190;
  localparam logic [WORD_BITS-1:0]  REF_MAX      = 13'd8191;
  localparam logic [COUNT_BITS-1:0] NO_PAGE      = 7'd64;
  localparam logic [COUNT_BITS-1:0] QUOTA_RST    = 7'd64;
  localparam logic [WORD_BITS-1:0]  HDR_WORDS    = 13'd2;

  localparam logic [2:0] CMD_ALLOC  = 3'd0;
  localparam logic [2:0] CMD_SHRINK = 3'd1;
  localparam logic [2:0] CMD_FREE   = 3'd2;
  localparam logic [2:0] CMD_REUSE  = 3'd3;
  localparam logic [2:0] CMD_LOCATE = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_PAGE   = 2'd2;
  localparam logic [1:0] ST_BAD       = 2'd3;

  typedef struct packed {
    logic [2:0]           command;
    logic [WORD_BITS-1:0] word_count;
    logic [PAGE_BITS-1:0] page_number;
    logic [WORD_BITS-1:0] page_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [PAGE_BITS-1:0] result_page;
    logic [WORD_BITS-1:0] result_offset;
    logic [18:0]          word_address;
    logic                 page_released;
  } rsp_t;

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } rpba_state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } rpba_cmd_t;

  typedef struct packed {
    logic slot_free;
  } rpba_status_t;

endpackage
`default_nettype wire

[rtl/refcounted_page_bump_allocator.sv]
// top level of the page bump allocator with per-page reference counts
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   rpba_pkg::req_t
//   rsp       out        rsp_valid/rsp_stall   rpba_pkg::rsp_t
//   quota     in         quota_we              quota_wdata (7 bits)
//
// a request passes an accept step, which reads the fill and reference count
// memories, and an execute step, which updates them and loads the result register.
// the result register holds one result, and the next request is taken while it
// waits. a stalled result holds the execute step.
// reset is synchronous and needs no clearing pass.
`default_nettype none
module refcounted_page_bump_allocator (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire rpba_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output rpba_pkg::rsp_t      rsp,
  input  wire logic           quota_we,
  input  wire logic [6:0]     quota_wdata
);
  import rpba_pkg::*;

  rpba_cmd_t    ctl;
  rpba_status_t stat;

  rpba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  rpba_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .quota_we    (quota_we),
    .quota_wdata (quota_wdata),
    .ctl         (ctl),
    .stat        (stat),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp)
  );

endmodule
`default_nettype wire

[rtl/rpba_ctrl.sv]
// sequencer for the page bump allocator: accept, then execute and write back
`default_nettype none
module rpba_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire rpba_pkg::rpba_status_t stat,
  output rpba_pkg::rpba_cmd_t        ctl
);
  import rpba_pkg::*;

  rpba_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    req_stall  = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.slot_free) begin
          ctl.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/rpba_dp.sv]
// datapath: page count memories, pool bitmap, free page search and result register
`default_nettype none
module rpba_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rpba_pkg::req_t      req,
  input  wire logic                quota_we,
  input  wire logic [6:0]          quota_wdata,
  input  wire rpba_pkg::rpba_cmd_t ctl,
  output rpba_pkg::rpba_status_t   stat,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output rpba_pkg::rsp_t           rsp
);
  import rpba_pkg::*;

  logic [WORD_BITS-1:0]  mem_fill [PAGE_COUNT];
  logic [WORD_BITS-1:0]  mem_ref  [PAGE_COUNT];
  logic [WORD_BITS-1:0]  rd_fill, rd_ref;
  req_t                  req_q;
  logic [PAGE_COUNT-1:0] held;
  logic [COUNT_BITS-1:0] held_pages, current_page, quota;

  logic [GROUPS-1:0]     grp_free;
  logic [GROUP_BITS-1:0] grp_idx [GROUPS];
  logic [GROUPS-1:0]     grp_free_c;
  logic [GROUP_BITS-1:0] grp_idx_c [GROUPS];

  logic [PAGE_BITS-1:0]  rd_addr;
  logic                  free_found;
  logic [PAGE_BITS-1:0]  free_page;

  logic                  wr_fill_en, wr_ref_en;
  logic [PAGE_BITS-1:0]  wr_addr;
  logic [WORD_BITS-1:0]  wr_fill, wr_ref;
  logic                  held_set, held_clr;
  logic [PAGE_BITS-1:0]  held_addr;
  logic [COUNT_BITS-1:0] held_pages_next, current_page_next;
  rsp_t                  rsp_next;

  logic                  cur_valid, pg_is_cur, can_take;
  logic [WORD_BITS:0]    fill_sum;
  logic [WORD_BITS-1:0]  ref_dec;

  assign rd_addr = (req.command == CMD_ALLOC) ? current_page[PAGE_BITS-1:0]
                                              : req.page_number;
  assign stat.slot_free = !rsp_valid || !rsp_stall;

  // count memories, read on transfer, written on commit
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rd_fill <= mem_fill[rd_addr];
      rd_ref  <= mem_ref[rd_addr];
      req_q   <= req;
    end
    if (ctl.commit && wr_fill_en) begin
      mem_fill[wr_addr] <= wr_fill;
    end
    if (ctl.commit && wr_ref_en) begin
      mem_ref[wr_addr] <= wr_ref;
    end
  end

  // first stage of the free page search: lowest free page in each group
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_free_c[g] = 1'b0;
      grp_idx_c[g]  = '0;
      for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
        if (!held[g*GROUP_SIZE + b]) begin
          grp_free_c[g] = 1'b1;
          grp_idx_c[g]  = GROUP_BITS'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_free <= grp_free_c;
    grp_idx  <= grp_idx_c;
  end

  // second stage: lowest group with a free page
  always_comb begin
    free_found = 1'b0;
    free_page  = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      if (grp_free[g]) begin
        free_found = 1'b1;
        free_page  = {(PAGE_BITS-GROUP_BITS)'(g), grp_idx[g]};
      end
    end
  end

  always_comb begin
    cur_valid         = (current_page != NO_PAGE);
    pg_is_cur         = (current_page == {1'b0, req_q.page_number});
    can_take          = (held_pages < quota) && free_found;
    fill_sum          = {1'b0, rd_fill} + {1'b0, req_q.word_count};
    ref_dec           = rd_ref - 13'd1;
    wr_fill_en        = 1'b0;
    wr_ref_en         = 1'b0;
    wr_addr           = req_q.page_number;
    wr_fill           = '0;
    wr_ref            = '0;
    held_set          = 1'b0;
    held_clr          = 1'b0;
    held_addr         = req_q.page_number;
    held_pages_next   = held_pages;
    current_page_next = current_page;
    rsp_next          = '0;
    rsp_next.status   = ST_BAD;
    case (req_q.command)
      CMD_ALLOC: begin
        if (req_q.word_count == '0) begin
          rsp_next.status = ST_BAD;
        end else if (req_q.word_count > USABLE_WORDS) begin
          rsp_next.status = ST_TOO_LARGE;
        end else if (cur_valid && fill_sum <= {1'b0, USABLE_WORDS}) begin
          wr_addr                = current_page[PAGE_BITS-1:0];
          wr_fill_en             = 1'b1;
          wr_fill                = fill_sum[WORD_BITS-1:0];
          wr_ref_en              = 1'b1;
          wr_ref                 = (rd_ref < REF_MAX) ? rd_ref + 13'd1 : rd_ref;
          rsp_next.status        = ST_OK;
          rsp_next.result_page   = current_page[PAGE_BITS-1:0];
          rsp_next.result_offset = rd_fill;
        end else if (can_take) begin
          wr_addr                = free_page;
          wr_fill_en             = 1'b1;
          wr_fill                = req_q.word_count;
          wr_ref_en              = 1'b1;
          wr_ref                 = 13'd1;
          held_set               = 1'b1;
          held_addr              = free_page;
          held_pages_next        = held_pages + 7'd1;
          current_page_next      = {1'b0, free_page};
          rsp_next.status        = ST_OK;
          rsp_next.result_page   = free_page;
        end else begin
          current_page_next = NO_PAGE;
          rsp_next.status   = ST_NO_PAGE;
        end
      end
      CMD_SHRINK: begin
        if (pg_is_cur) begin
          wr_fill_en           = 1'b1;
          rsp_next.result_page = req_q.page_number;
          if (req_q.word_count > rd_fill) begin
            wr_fill         = '0;
            rsp_next.status = ST_BAD;
          end else begin
            wr_fill                = rd_fill - req_q.word_count;
            rsp_next.status        = ST_OK;
            rsp_next.result_offset = rd_fill - req_q.word_count;
          end
        end
      end
      CMD_FREE: begin
        if (held[req_q.page_number] && rd_ref != '0) begin
          rsp_next.status = ST_OK;
          wr_ref_en       = 1'b1;
          wr_ref          = ref_dec;
          if (ref_dec == '0) begin
            wr_fill_en = 1'b1;
            wr_fill    = '0;
            if (!pg_is_cur) begin
              held_clr               = 1'b1;
              rsp_next.page_released = 1'b1;
              if (held_pages != '0) begin
                held_pages_next = held_pages - 7'd1;
              end
            end
          end
        end
      end
      CMD_REUSE: begin
        if (cur_valid || held[req_q.page_number]) begin
          rsp_next.status = ST_BAD;
        end else if (held_pages >= quota) begin
          rsp_next.status = ST_NO_PAGE;
        end else begin
          wr_fill_en        = 1'b1;
          wr_ref_en         = 1'b1;
          held_set          = 1'b1;
          held_pages_next   = held_pages + 7'd1;
          current_page_next = {1'b0, req_q.page_number};
          rsp_next.status   = ST_OK;
        end
      end
      CMD_LOCATE: begin
        if (req_q.page_offset < USABLE_WORDS) begin
          rsp_next.status       = ST_OK;
          rsp_next.word_address = {req_q.page_number, req_q.page_offset + HDR_WORDS};
        end
      end
      default: rsp_next.status = ST_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held         <= '0;
      held_pages   <= '0;
      current_page <= NO_PAGE;
      quota        <= QUOTA_RST;
      rsp_valid    <= 1'b0;
    end else begin
      if (quota_we) begin
        quota <= quota_wdata;
      end
      if (ctl.commit) begin
        if (held_set) begin
          held[held_addr] <= 1'b1;
        end
        if (held_clr) begin
          held[held_addr] <= 1'b0;
        end
        held_pages   <= held_pages_next;
        current_page <= current_page_next;
        rsp_valid    <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      rsp <= rsp_next;
    end
  end

endmodule
`default_nettype wire
